### hw/rtl/bilinear_image_sampler_assert.svh
// Assertion shorthands for the checker file of the sampler (bis_checker.sv).
// Both sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef BILINEAR_IMAGE_SAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

  localparam int PIX_W      = 16;
  localparam int ADDR_W     = 18;
  localparam int POS_W      = 17;
  localparam int DIM_W      = 10;
  localparam int OUT_W      = 24;
  localparam int DIM_MIN    = 2;
  localparam int DIM_RESET  = 512;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 24;

  // Transaction kinds on the input channel.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Per-query flags that ride along with the arithmetic.
  typedef struct packed {
    logic oob;
    logic last;
  } bis_tag_t;

endpackage

### hw/rtl/bis_ram.sv
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### hw/rtl/bis_front.sv
`timescale 1ns / 1ps

module bis_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  in_op_i,
  input  logic [bis_pkg::ADDR_W-1:0]            in_addr_i,
  input  logic [bis_pkg::PIX_W-1:0]             in_value_i,
  input  logic [bis_pkg::POS_W-1:0]             in_x_i,
  input  logic [bis_pkg::POS_W-1:0]             in_y_i,
  input  logic                                  in_last_i,
  input  logic [bis_pkg::DIM_W-1:0]             width_i,
  input  logic [bis_pkg::DIM_W-1:0]             height_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output bis_pkg::bis_tag_t                     out_tag_o,
  output logic [FRAC_BITS-1:0]                  out_fx_o,
  output logic [FRAC_BITS-1:0]                  out_fy_o,
  output logic [3:0][bis_pkg::PIX_W-1:0]        out_pix_o
);

  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int BANK_DEPTH = (DEPTH + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int COL_W      = bis_pkg::POS_W - FRAC_BITS;
  localparam int PROD_W     = COL_W + bis_pkg::DIM_W;

  // Stage A: input register.
  logic                         va_q;
  logic                         op_a_q;
  logic [bis_pkg::ADDR_W-1:0]   addr_a_q;
  logic [bis_pkg::PIX_W-1:0]    val_a_q;
  logic [bis_pkg::POS_W-1:0]    x_a_q;
  logic [bis_pkg::POS_W-1:0]    y_a_q;
  logic                         last_a_q;

  logic [COL_W-1:0]             col_a;
  logic [COL_W-1:0]             row_a;
  logic                         oob_a;
  logic [AW-1:0]                prod_a;
  logic [AW-1:0]                colw_a;
  logic [AW-1:0]                colx_a;

  // Stage B: row product ready, memory addresses and writes issued.
  logic                         vb_q;
  logic                         load_b_q;
  logic [bis_pkg::ADDR_W-1:0]   addr_b_q;
  logic [bis_pkg::PIX_W-1:0]    val_b_q;
  logic [AW-1:0]                prod_b_q;
  logic [AW-1:0]                col_b_q;
  logic [AW-1:0]                colw_b_q;
  logic [FRAC_BITS-1:0]         fx_b_q;
  logic [FRAC_BITS-1:0]         fy_b_q;
  bis_pkg::bis_tag_t            tag_b_q;

  logic [AW-1:0]                a0_b;
  logic [AW-1:0]                a1_b;
  logic [AW:0]                  a0_inc;
  logic [AW:0]                  a1_inc;
  logic                         load_hit;
  logic [BAW-1:0]               waddr_b;

  // Stage C: memory read data.
  logic                         vc_q;
  bis_pkg::bis_tag_t            tag_c_q;
  logic [FRAC_BITS-1:0]         fx_c_q;
  logic [FRAC_BITS-1:0]         fy_c_q;
  logic                         par0_c_q;
  logic                         par1_c_q;

  logic [bis_pkg::PIX_W-1:0]    even_q0;
  logic [bis_pkg::PIX_W-1:0]    even_q1;
  logic [bis_pkg::PIX_W-1:0]    odd_q0;
  logic [bis_pkg::PIX_W-1:0]    odd_q1;

  logic                         rdy_a;
  logic                         rdy_b;
  logic                         rdy_c;

  // A load never enters stage C, so it can always leave stage B.
  assign rdy_c      = !vc_q || out_ready_i;
  assign rdy_b      = !vb_q || load_b_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q && !load_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      op_a_q   <= in_op_i;
      addr_a_q <= in_addr_i;
      val_a_q  <= in_value_i;
      x_a_q    <= in_x_i;
      y_a_q    <= in_y_i;
      last_a_q <= in_last_i;
    end
  end

  assign col_a  = x_a_q[bis_pkg::POS_W-1:FRAC_BITS];
  assign row_a  = y_a_q[bis_pkg::POS_W-1:FRAC_BITS];
  // The right and lower neighbors must exist even when their weight is zero.
  assign oob_a  = ((PROD_W'(col_a) + PROD_W'(1)) >= PROD_W'(width_i)) ||
                  ((PROD_W'(row_a) + PROD_W'(1)) >= PROD_W'(height_i));
  assign prod_a = AW'(PROD_W'(row_a) * PROD_W'(width_i));
  assign colw_a = AW'(PROD_W'(col_a) + PROD_W'(width_i));
  assign colx_a = AW'(col_a);

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      load_b_q      <= (op_a_q == bis_pkg::OP_LOAD);
      addr_b_q      <= addr_a_q;
      val_b_q       <= val_a_q;
      prod_b_q      <= prod_a;
      col_b_q       <= colx_a;
      colw_b_q      <= colw_a;
      fx_b_q        <= x_a_q[FRAC_BITS-1:0];
      fy_b_q        <= y_a_q[FRAC_BITS-1:0];
      tag_b_q.oob   <= oob_a;
      tag_b_q.last  <= last_a_q;
    end
  end

  // The store is split by flat address parity: each horizontal pair of
  // neighbors has one pixel in either bank, so two read ports per bank give
  // all four neighbors at once.
  assign a0_b     = prod_b_q + col_b_q;
  assign a1_b     = prod_b_q + colw_b_q;
  assign a0_inc   = (AW + 1)'(a0_b) + (AW + 1)'(1);
  assign a1_inc   = (AW + 1)'(a1_b) + (AW + 1)'(1);
  assign load_hit = vb_q && load_b_q && (32'(addr_b_q) < 32'(DEPTH));
  assign waddr_b  = BAW'(addr_b_q[bis_pkg::ADDR_W-1:1]);

  bis_ram #(
    .WIDTH (bis_pkg::PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i    (clk_i),
    .we_i     (load_hit && !addr_b_q[0]),
    .waddr_i  (waddr_b),
    .wdata_i  (val_b_q),
    .re_i     (rdy_c),
    .raddr0_i (BAW'(a0_inc[AW:1])),
    .raddr1_i (BAW'(a1_inc[AW:1])),
    .rdata0_o (even_q0),
    .rdata1_o (even_q1)
  );

  bis_ram #(
    .WIDTH (bis_pkg::PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i    (clk_i),
    .we_i     (load_hit && addr_b_q[0]),
    .waddr_i  (waddr_b),
    .wdata_i  (val_b_q),
    .re_i     (rdy_c),
    .raddr0_i (BAW'(a0_b[AW-1:1])),
    .raddr1_i (BAW'(a1_b[AW-1:1])),
    .rdata0_o (odd_q0),
    .rdata1_o (odd_q1)
  );

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      tag_c_q  <= tag_b_q;
      fx_c_q   <= fx_b_q;
      fy_c_q   <= fy_b_q;
      par0_c_q <= a0_b[0];
      par1_c_q <= a1_b[0];
    end
  end

  assign out_valid_o  = vc_q;
  assign out_tag_o    = tag_c_q;
  assign out_fx_o     = fx_c_q;
  assign out_fy_o     = fy_c_q;
  assign out_pix_o[0] = par0_c_q ? odd_q0  : even_q0;
  assign out_pix_o[1] = par0_c_q ? even_q0 : odd_q0;
  assign out_pix_o[2] = par1_c_q ? odd_q1  : even_q1;
  assign out_pix_o[3] = par1_c_q ? even_q1 : odd_q1;

endmodule

### hw/rtl/bis_interp.sv
`timescale 1ns / 1ps

module bis_interp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bis_pkg::bis_tag_t               in_tag_i,
  input  logic [FRAC_BITS-1:0]            in_fx_i,
  input  logic [FRAC_BITS-1:0]            in_fy_i,
  input  logic [3:0][bis_pkg::PIX_W-1:0]  in_pix_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bis_pkg::OUT_W-1:0]       out_sample_o,
  output logic                            out_oob_o,
  output logic                            out_last_o
);

  localparam int WT_W  = FRAC_BITS + 1;
  localparam int T_W   = bis_pkg::PIX_W + FRAC_BITS;
  localparam int R_W   = bis_pkg::PIX_W + 2 * FRAC_BITS;
  localparam int SUM_W = (R_W + 1 > FRAC_BITS + bis_pkg::OUT_W) ?
                         R_W + 1 : FRAC_BITS + bis_pkg::OUT_W;
  localparam logic [WT_W-1:0]  ONE  = WT_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic                       vd_q;
  logic                       ve_q;
  logic                       vf_q;
  logic                       vo_q;
  logic                       rdy_d;
  logic                       rdy_e;
  logic                       rdy_f;
  logic                       rdy_o;

  logic [WT_W-1:0]            gx_d;
  logic [WT_W-1:0]            fx_w;
  logic [3:0][T_W-1:0]        t_q;
  logic [WT_W-1:0]            gy_d_q;
  logic [WT_W-1:0]            fy_d_q;
  bis_pkg::bis_tag_t          tag_d_q;

  logic [1:0][T_W-1:0]        s_q;
  logic [WT_W-1:0]            gy_e_q;
  logic [WT_W-1:0]            fy_e_q;
  bis_pkg::bis_tag_t          tag_e_q;

  logic [1:0][R_W-1:0]        r_q;
  bis_pkg::bis_tag_t          tag_f_q;

  logic [SUM_W-1:0]           sum_f;
  logic [bis_pkg::OUT_W-1:0]  sample_q;
  bis_pkg::bis_tag_t          tag_o_q;

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_f      = !vf_q || rdy_o;
  assign rdy_e      = !ve_q || rdy_f;
  assign rdy_d      = !vd_q || rdy_e;
  assign in_ready_o = rdy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_d) begin
        vd_q <= in_valid_i;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
      if (rdy_f) begin
        vf_q <= ve_q;
      end
      if (rdy_o) begin
        vo_q <= vf_q;
      end
    end
  end

  // Horizontal weighting of each neighbor.
  assign fx_w = WT_W'(in_fx_i);
  assign gx_d = ONE - fx_w;

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      t_q[0]  <= T_W'(T_W'(in_pix_i[0]) * T_W'(gx_d));
      t_q[1]  <= T_W'(T_W'(in_pix_i[1]) * T_W'(fx_w));
      t_q[2]  <= T_W'(T_W'(in_pix_i[2]) * T_W'(gx_d));
      t_q[3]  <= T_W'(T_W'(in_pix_i[3]) * T_W'(fx_w));
      gy_d_q  <= ONE - WT_W'(in_fy_i);
      fy_d_q  <= WT_W'(in_fy_i);
      tag_d_q <= in_tag_i;
    end
  end

  // A row sum is at most the largest pixel times one, so it fits T_W bits.
  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      s_q[0]  <= t_q[0] + t_q[1];
      s_q[1]  <= t_q[2] + t_q[3];
      gy_e_q  <= gy_d_q;
      fy_e_q  <= fy_d_q;
      tag_e_q <= tag_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f) begin
      r_q[0]  <= R_W'(R_W'(s_q[0]) * R_W'(gy_e_q));
      r_q[1]  <= R_W'(R_W'(s_q[1]) * R_W'(fy_e_q));
      tag_f_q <= tag_e_q;
    end
  end

  // Round to nearest with halves going up, then drop the extra fraction bits.
  assign sum_f = SUM_W'(r_q[0]) + SUM_W'(r_q[1]) + HALF;

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      sample_q <= tag_f_q.oob ? '0 : sum_f[FRAC_BITS +: bis_pkg::OUT_W];
      tag_o_q  <= tag_f_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign out_sample_o = sample_q;
  assign out_oob_o    = tag_o_q.oob;
  assign out_last_o   = tag_o_q.last;

endmodule

### hw/rtl/bilinear_image_sampler.sv
`timescale 1ns / 1ps
// Bilinear image sampler.
// The input stream carries two kinds of transactions, told apart by tuser:
// a load writes one 16-bit pixel at a flat address (row * width + column)
// and gives no result; a query gives x and y in unsigned fixed point with
// FRAC_BITS fraction bits and gives one result with the interpolated value.
// Loads for an image must precede the queries that read it. The image size
// is set through the configuration write port, which the user must write
// only while no query is in flight; the block itself does not enforce this.
// A query whose right or lower neighbor falls outside the image returns
// zero with the out-of-range flag (output tuser) set; tlast is echoed.
// Throughput is one transaction per cycle unless the output stalls: the pixel
// store is split into two banks by address parity, each with two read ports,
// so all four neighbors are read together. A result passes the input
// register, address, memory read, two multiply stages with an add between and
// the output register. When the output is stalled the pipeline keeps taking
// transactions until its seven stages are full, then drops s_axis_tready;
// nothing is lost. Reset empties the pipeline and sets width and height back
// to 512; the pixel store is not cleared and must be reloaded.
module bilinear_image_sampler #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [17:0] pixel_address, [33:18] pixel_value, [50:34] x_pos, [67:51] y_pos
  input  logic [bis_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] op
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [23:0] sample_value
  output logic [bis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] out_of_range
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [bis_pkg::DIM_W-1:0]       cfg_data_i
);

  localparam int DIM_LIMIT = (1 << bis_pkg::DIM_W) - 1;
  localparam int WCAP      = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int HCAP      = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
  localparam int WRST      = (WCAP < bis_pkg::DIM_RESET) ? WCAP : bis_pkg::DIM_RESET;
  localparam int HRST      = (HCAP < bis_pkg::DIM_RESET) ? HCAP : bis_pkg::DIM_RESET;
  localparam logic [bis_pkg::DIM_W-1:0] DMIN = bis_pkg::DIM_W'(bis_pkg::DIM_MIN);

  logic [bis_pkg::DIM_W-1:0]         width_q;
  logic [bis_pkg::DIM_W-1:0]         width_d;
  logic [bis_pkg::DIM_W-1:0]         height_q;
  logic [bis_pkg::DIM_W-1:0]         height_d;
  logic [bis_pkg::DIM_W-1:0]         width_wr;
  logic [bis_pkg::DIM_W-1:0]         height_wr;

  logic                              mid_valid;
  logic                              mid_ready;
  bis_pkg::bis_tag_t                 mid_tag;
  logic [FRAC_BITS-1:0]              mid_fx;
  logic [FRAC_BITS-1:0]              mid_fy;
  logic [3:0][bis_pkg::PIX_W-1:0]    mid_pix;

  // Written values saturate into the legal range of each dimension.
  assign width_wr  = (cfg_data_i < DMIN) ? DMIN :
                     (cfg_data_i > bis_pkg::DIM_W'(WCAP)) ? bis_pkg::DIM_W'(WCAP) :
                     cfg_data_i;
  assign height_wr = (cfg_data_i < DMIN) ? DMIN :
                     (cfg_data_i > bis_pkg::DIM_W'(HCAP)) ? bis_pkg::DIM_W'(HCAP) :
                     cfg_data_i;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bis_pkg::CFG_IDX_WIDTH:  width_d  = width_wr;
        bis_pkg::CFG_IDX_HEIGHT: height_d = height_wr;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bis_pkg::DIM_W'(WRST);
      height_q <= bis_pkg::DIM_W'(HRST);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  bis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[17:0]),
    .in_value_i  (s_axis_tdata[33:18]),
    .in_x_i      (s_axis_tdata[50:34]),
    .in_y_i      (s_axis_tdata[67:51]),
    .in_last_i   (s_axis_tlast),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_tag_o   (mid_tag),
    .out_fx_o    (mid_fx),
    .out_fy_o    (mid_fy),
    .out_pix_o   (mid_pix)
  );

  bis_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (mid_valid),
    .in_ready_o   (mid_ready),
    .in_tag_i     (mid_tag),
    .in_fx_i      (mid_fx),
    .in_fy_i      (mid_fy),
    .in_pix_i     (mid_pix),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_oob_o    (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

### hw/rtl/bis_checker.sv
`timescale 1ns / 1ps
`include "bilinear_image_sampler_assert.svh"

module bis_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // Queries accepted whose result has not yet been taken.
  logic [3:0] pend_q;
  logic [3:0] pend_d;
  logic       q_acc;
  logic       r_acc;
  logic       oob_out;
  logic       out_stall;
  logic [bis_pkg::M_TDATA_W+1:0] out_word;

  assign q_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == bis_pkg::OP_QUERY);
  assign r_acc = m_axis_tvalid && m_axis_tready;

  assign oob_out   = m_axis_tvalid && m_axis_tuser;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};

  always_comb begin
    pend_d = pend_q;
    if (q_acc && !r_acc) begin
      pend_d = pend_q + 4'd1;
    end else if (!q_acc && r_acc) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BIS_ASSERT_SAME(a_result_needs_query, m_axis_tvalid, pend_q != 4'd0, "orphan result")
  `BIS_ASSERT_SAME(a_oob_gives_zero, oob_out, m_axis_tdata == '0, "nonzero out-of-range result")
  `BIS_ASSERT_SAME(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input stalled when empty")
  `BIS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (.*);
